FILE: src/rid_pkg.sv
package rid_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int MAX_DIGITS  = 32;
    localparam int CHAR_BITS   = 8;
    localparam int COUNT_BITS  = 6;
    localparam int DIGIT_BITS  = $clog2(MAX_DIGITS);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // quotient bits retired per division cycle
    localparam int DIV_BITS    = 8;
    localparam int DIV_STEPS   = VALUE_BITS / DIV_BITS;
    localparam int DIV_STEP_W  = $clog2(DIV_STEPS);

    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_NONE  = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIGIT_COUNT = 3'd0,
        REG_ALPHA_0     = 3'd1,
        REG_ALPHA_1     = 3'd2,
        REG_ALPHA_2     = 3'd3,
        REG_ALPHA_3     = 3'd4
    } t_reg_idx;

    typedef logic [MAX_DIGITS-1:0][CHAR_BITS-1:0] t_alpha;

    typedef struct packed {
        logic                  bad;
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CHECK,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_EMIT
    } t_back_state;

endpackage

FILE: src/rid_queue.sv
module rid_queue
    import rid_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: src/rid_front.sv
module rid_front
    import rid_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic [COUNT_BITS-1:0]        i_digit_count,
    input  t_alpha                       i_alpha,
    input  logic                         i_q_full,
    output logic                         o_push,
    output t_job                         o_job
);

    t_front_state          r_state;
    t_front_state          n_state;
    logic [DIGIT_BITS-1:0] r_idx;
    logic [DIGIT_BITS-1:0] n_idx;
    logic                  r_bad;
    logic                  n_bad;
    logic                  r_neg;
    logic [VALUE_BITS-1:0] r_mag;

    logic                  accept;
    logic                  count_bad;
    logic                  char_bad;
    logic [CHAR_BITS-1:0]  cur_char;

    assign busy   = (r_state != F_IDLE);
    assign accept = start && !busy;

    assign count_bad = (i_digit_count < COUNT_BITS'(2))
                    || (i_digit_count > COUNT_BITS'(MAX_DIGITS));

    // character r_idx against the sign characters and every later used one
    assign cur_char = i_alpha[r_idx];
    always_comb begin
        char_bad = (cur_char == CH_PLUS) || (cur_char == CH_MINUS);
        for (int j = 0; j < MAX_DIGITS; j++) begin
            if ((COUNT_BITS'(j) > {1'b0, r_idx}) && (COUNT_BITS'(j) < i_digit_count)
                && (i_alpha[j] == cur_char)) begin
                char_bad = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_bad   = r_bad;
        o_push  = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    n_bad = count_bad;
                    n_state = count_bad ? F_PUSH : F_CHECK;
                end
            end
            F_CHECK: begin
                if (char_bad) begin
                    n_bad   = 1'b1;
                    n_state = F_PUSH;
                end else if ({1'b0, r_idx} == i_digit_count - 1'b1) begin
                    n_state = F_PUSH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_idx   <= '0;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_bad   <= n_bad;
        end
    end

    // most negative value negates to 2^31, which fits the unsigned magnitude
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg <= i_value[VALUE_BITS-1];
            r_mag <= i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;
        end
    end

    assign o_job.bad = r_bad;
    assign o_job.neg = r_neg;
    assign o_job.mag = r_mag;

endmodule

FILE: src/rid_back.sv
module rid_back
    import rid_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_job                  i_job,
    output logic                  o_pop,
    input  logic [COUNT_BITS-1:0] i_digit_count,
    input  t_alpha                i_alpha,
    output logic                  o_valid,
    output logic [CHAR_BITS-1:0]  o_char_out,
    output logic                  o_last,
    output logic                  o_status
);

    // DIV_BITS steps of restoring division; remainder stays below the radix
    function automatic logic [COUNT_BITS+VALUE_BITS-1:0] div_step(
        input logic [VALUE_BITS-1:0] q,
        input logic [COUNT_BITS-1:0] r,
        input logic [COUNT_BITS-1:0] d
    );
        logic [VALUE_BITS-1:0] qq;
        logic [COUNT_BITS-1:0] rr;
        qq = q;
        rr = r;
        for (int k = 0; k < DIV_BITS; k++) begin
            rr = {rr[COUNT_BITS-2:0], qq[VALUE_BITS-1]};
            qq = {qq[VALUE_BITS-2:0], 1'b0};
            if (rr >= d) begin
                rr    = rr - d;
                qq[0] = 1'b1;
            end
        end
        return {rr, qq};
    endfunction

    t_back_state           r_state,  n_state;
    logic [VALUE_BITS-1:0] r_quot,   n_quot;
    logic [COUNT_BITS-1:0] r_rem,    n_rem;
    logic [DIV_STEP_W-1:0] r_step,   n_step;
    logic [COUNT_BITS-1:0] r_total,  n_total;
    logic [DIGIT_BITS-1:0] r_idx,    n_idx;
    logic                  r_rd_valid, n_rd_valid;
    logic                  r_rd_last,  n_rd_last;
    logic [DIGIT_BITS-1:0] r_rd_data;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_BITS-1:0]  r_out_char,  n_out_char;
    logic                  r_out_last,  n_out_last;
    logic                  r_out_status, n_out_status;

    logic [DIGIT_BITS-1:0] digit_mem [MAX_DIGITS];
    logic                  mem_we;
    logic                  rd_en;

    logic [VALUE_BITS-1:0] div_q;
    logic [COUNT_BITS-1:0] div_r;

    assign {div_r, div_q} = div_step(r_quot, r_rem, i_digit_count);

    always_comb begin
        n_state      = r_state;
        n_quot       = r_quot;
        n_rem        = r_rem;
        n_step       = r_step;
        n_total      = r_total;
        n_idx        = r_idx;
        n_rd_valid   = 1'b0;
        n_rd_last    = r_rd_last;
        n_out_valid  = 1'b0;
        n_out_char   = r_out_char;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        o_pop        = 1'b0;
        mem_we       = 1'b0;
        rd_en        = 1'b0;

        if (r_rd_valid) begin
            n_out_valid  = 1'b1;
            n_out_char   = i_alpha[r_rd_data];
            n_out_last   = r_rd_last;
            n_out_status = 1'b0;
        end

        case (r_state)
            B_IDLE: begin
                // wait for the last digit to leave the read stage
                if (i_q_valid && !r_rd_valid) begin
                    o_pop = 1'b1;
                    if (i_job.bad) begin
                        n_out_valid  = 1'b1;
                        n_out_char   = CH_NONE;
                        n_out_last   = 1'b1;
                        n_out_status = 1'b1;
                    end else begin
                        if (i_job.neg) begin
                            n_out_valid  = 1'b1;
                            n_out_char   = CH_MINUS;
                            n_out_last   = 1'b0;
                            n_out_status = 1'b0;
                        end
                        n_quot  = i_job.mag;
                        n_rem   = '0;
                        n_step  = '0;
                        n_total = '0;
                        n_state = B_DIV;
                    end
                end
            end
            B_DIV: begin
                n_quot = div_q;
                n_rem  = div_r;
                n_step = r_step + 1'b1;
                if (r_step == DIV_STEP_W'(DIV_STEPS - 1)) begin
                    // one digit done; zero input still yields one digit
                    mem_we  = 1'b1;
                    n_total = r_total + 1'b1;
                    n_rem   = '0;
                    n_step  = '0;
                    if (div_q == '0) begin
                        n_idx   = r_total[DIGIT_BITS-1:0];
                        n_state = B_EMIT;
                    end
                end
            end
            B_EMIT: begin
                rd_en      = 1'b1;
                n_rd_valid = 1'b1;
                n_rd_last  = (r_idx == '0);
                n_idx      = r_idx - 1'b1;
                if (r_idx == '0) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_quot      <= '0;
            r_total     <= '0;
            r_step      <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_quot      <= n_quot;
            r_total     <= n_total;
            r_step      <= n_step;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem        <= n_rem;
        r_idx        <= n_idx;
        r_rd_last    <= n_rd_last;
        r_out_char   <= n_out_char;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            digit_mem[r_total[DIGIT_BITS-1:0]] <= div_r[DIGIT_BITS-1:0];
        end
        if (rd_en) begin
            r_rd_data <= digit_mem[r_idx];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_char_out = r_out_char;
    assign o_last     = r_out_last;
    assign o_status   = r_out_status;

endmodule

FILE: src/radix_integer_to_digits.sv
// Converts a signed 32-bit value to text in radix digit_count, one character
// per o_valid pulse, most significant digit first, o_last on the final one;
// a negative value leads with '-'. Results come as one-cycle strobes that
// cannot be held off. The front checks one alphabet character per cycle; the
// back divides by the radix 8 quotient bits per cycle, then reads one digit
// per cycle from the digit memory. A two-entry queue lets the next item be
// checked while the current one is divided and emitted; busy is high while
// the front is checking an item or waiting to push it into the queue. An
// invalid digit count or alphabet yields a single result with status = 1,
// char_out = 0 and last = 1. Configuration must be written only while no item
// is in flight; the block itself does not enforce this. Indexes above 4 are
// ignored.
module radix_integer_to_digits
    import rid_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    output logic                         o_valid,
    output logic [CHAR_BITS-1:0]         o_char_out,
    output logic                         o_last,
    output logic                         o_status
);

    logic [COUNT_BITS-1:0] r_digit_count;
    logic [CFG_DATA_W-1:0] r_alpha_0;
    logic [CFG_DATA_W-1:0] r_alpha_1;
    logic [CFG_DATA_W-1:0] r_alpha_2;
    logic [CFG_DATA_W-1:0] r_alpha_3;

    t_alpha alpha;
    logic   q_full;
    logic   q_valid;
    logic   push;
    logic   pop;
    t_job   push_job;
    t_job   pop_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= '0;
            r_alpha_0     <= '0;
            r_alpha_1     <= '0;
            r_alpha_2     <= '0;
            r_alpha_3     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DIGIT_COUNT: r_digit_count <= i_cfg_data[COUNT_BITS-1:0];
                REG_ALPHA_0:     r_alpha_0     <= i_cfg_data;
                REG_ALPHA_1:     r_alpha_1     <= i_cfg_data;
                REG_ALPHA_2:     r_alpha_2     <= i_cfg_data;
                REG_ALPHA_3:     r_alpha_3     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // character k sits in byte k of the concatenated words
    assign alpha = {r_alpha_3, r_alpha_2, r_alpha_1, r_alpha_0};

    rid_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_digit_count (r_digit_count),
        .i_alpha       (alpha),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    rid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    rid_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_job         (pop_job),
        .o_pop         (pop),
        .i_digit_count (r_digit_count),
        .i_alpha       (alpha),
        .o_valid       (o_valid),
        .o_char_out    (o_char_out),
        .o_last        (o_last),
        .o_status      (o_status)
    );

endmodule
